// ===== rtl/framebuffer_pixel_pack_writer_top_defines.svh =====
// Assertion macros shared by the framebuffer pixel pack writer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FRAMEBUFFER_PIXEL_PACK_WRITER_TOP_DEFINES_SVH
`define FRAMEBUFFER_PIXEL_PACK_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FBPPW_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fbppw assertion failed");

// Next-cycle implication, checked outside reset
`define FBPPW_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fbppw assertion failed");

`endif

// ===== rtl/fbppw_pkg.sv =====
// Shared widths, register indexes and reset values of the pixel pack writer.
// Depends on nothing; used by the channel interfaces and the top level.
package fbppw_pkg;

    localparam int PIXEL_W    = 32;
    localparam int COORD_W    = 12;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 3;
    localparam int LAYOUT_W   = 11;
    localparam int STRIDE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RED_LAYOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LAYOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LAYOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LAYOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd7;

    // Byte counts
    localparam logic [COUNT_W-1:0] BPP_2 = 3'd2;
    localparam logic [COUNT_W-1:0] BPP_3 = 3'd3;
    localparam logic [COUNT_W-1:0] BPP_4 = 3'd4;

    // Reset layouts: 8 bits each, red at 16, green at 8, blue at 0, no alpha
    localparam logic [LAYOUT_W-1:0] RST_RED_LAYOUT   = 11'd272;
    localparam logic [LAYOUT_W-1:0] RST_GREEN_LAYOUT = 11'd264;
    localparam logic [LAYOUT_W-1:0] RST_BLUE_LAYOUT  = 11'd256;
    localparam logic [LAYOUT_W-1:0] RST_ALPHA_LAYOUT = 11'd0;

endpackage

// ===== rtl/fbppw_in_if.sv =====
// Input channel of the pixel pack writer: one ARGB pixel and its coordinates.
// Depends on fbppw_pkg for the field widths.
interface fbppw_in_if;

    logic                              valid;
    logic                              ready;
    logic [fbppw_pkg::PIXEL_W-1:0]     argb_pixel;
    logic [fbppw_pkg::COORD_W-1:0]     column;
    logic [fbppw_pkg::COORD_W-1:0]     row;

    modport source (output valid, output argb_pixel, output column, output row,
                    input ready);
    modport sink   (input valid, input argb_pixel, input column, input row,
                    output ready);

endinterface

// ===== rtl/fbppw_out_if.sv =====
// Output channel of the pixel pack writer: one framebuffer write.
// Depends on fbppw_pkg for the field widths.
interface fbppw_out_if;

    logic                              valid;
    logic                              ready;
    logic [fbppw_pkg::ADDR_W-1:0]      byte_address;
    logic [fbppw_pkg::PIXEL_W-1:0]     pixel_bytes;
    logic [fbppw_pkg::COUNT_W-1:0]     byte_count;

    modport source (output valid, output byte_address, output pixel_bytes,
                    output byte_count, input ready);
    modport sink   (input valid, input byte_address, input pixel_bytes,
                    input byte_count, output ready);

endinterface

// ===== rtl/framebuffer_pixel_pack_writer_top.sv =====
// Framebuffer pixel pack writer: converts ARGB8888 words into framebuffer writes.
// Depends on fbppw_pkg, fbppw_in_if, fbppw_out_if and the defines header.
//
// Accepts one pixel word per clock while the sink is not stalling and returns one
// write word per pixel: the pixel is first captured in an input register,
// then channel rescaling, packing and the address product (a 13x16 multiply)
// run in one combinational pass into the result register. Each channel is
// rescaled to its configured length with round-to-nearest, shifted to its
// offset and ORed in; bytes above byte_count read as zero, and bytes per
// pixel other than 2 or 3 act as 4. The result register and the input
// register form a two-deep pipeline, so a new pixel can be taken while a finished
// word waits for the sink. Write configuration only while no pixel is in
// flight.
module framebuffer_pixel_pack_writer_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fbppw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbppw_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    fbppw_in_if.sink                            pix_in,
    fbppw_out_if.source                         pix_out
);

`include "framebuffer_pixel_pack_writer_top_defines.svh"

    // Coordinate bits that take part in the address
    localparam int USE_W = (COORD_BITS < fbppw_pkg::COORD_W) ? COORD_BITS
                                                              : fbppw_pkg::COORD_W;
    localparam int SUM_W = USE_W + 1;
    localparam int PY_W  = SUM_W + fbppw_pkg::STRIDE_W;
    localparam int PX_W  = SUM_W + fbppw_pkg::COUNT_W;

    // Rescale one 8-bit channel: (v*(2^len-1)+127)/255 placed at its offset.
    // With len = 8k + r, v*2^len = 255*(w*S) + w where w = v<<r and
    // S = 0x..0101 (k bytes), so only a short remainder needs dividing.
    function automatic logic [31:0] rescale(input logic [7:0] v,
                                            input logic [fbppw_pkg::LAYOUT_W-1:0] layout);
        logic [5:0]  len;
        logic [4:0]  off;
        logic [5:0]  lenc;
        logic [2:0]  k;
        logic [2:0]  r;
        logic [14:0] w;
        logic [14:0] t;
        logic [23:0] t1;
        logic [23:0] tq;
        logic [31:0] q;
        len  = layout[10:5];
        off  = layout[4:0];
        lenc = (len >= 6'd32) ? 6'd32 : len;
        k    = lenc[5:3];
        r    = lenc[2:0];
        w    = 15'(v) << r;
        t    = w - 15'(v) + 15'd127;
        // floor(t/255) = ((t+1)*257) >> 16 for t below 2^16
        t1   = 24'(t) + 24'd1;
        tq   = t1 + (t1 << 8);
        q    = 32'(tq[23:16]);
        for (int i = 0; i < 4; i++)
        begin
            if (i < int'(k))
            begin
                q = q + (32'(w) << (8 * i));
            end
        end
        if (len == 6'd0)
        begin
            rescale = 32'd0;
        end
        else
        begin
            rescale = q << off;
        end
    endfunction

    // Configuration registers
    logic [fbppw_pkg::LAYOUT_W-1:0] red_layout_reg;
    logic [fbppw_pkg::LAYOUT_W-1:0] green_layout_reg;
    logic [fbppw_pkg::LAYOUT_W-1:0] blue_layout_reg;
    logic [fbppw_pkg::LAYOUT_W-1:0] alpha_layout_reg;
    logic [fbppw_pkg::COUNT_W-1:0]  bpp_reg;
    logic [fbppw_pkg::STRIDE_W-1:0] line_length_reg;
    logic [fbppw_pkg::COORD_W-1:0]  origin_x_reg;
    logic [fbppw_pkg::COORD_W-1:0]  origin_y_reg;

    // Input stage
    logic                           s1_valid_reg;
    logic [fbppw_pkg::PIXEL_W-1:0]  s1_argb_reg;
    logic [fbppw_pkg::COORD_W-1:0]  s1_column_reg;
    logic [fbppw_pkg::COORD_W-1:0]  s1_row_reg;

    // Result stage
    logic                           s2_valid_reg;
    logic [fbppw_pkg::ADDR_W-1:0]   s2_addr_reg;
    logic [fbppw_pkg::PIXEL_W-1:0]  s2_bytes_reg;
    logic [fbppw_pkg::COUNT_W-1:0]  s2_count_reg;

    logic                           s1_advance;
    logic                           in_take;
    logic [fbppw_pkg::COUNT_W-1:0]  bpp_eff;
    logic [fbppw_pkg::PIXEL_W-1:0]  packed_word;
    logic [fbppw_pkg::PIXEL_W-1:0]  byte_mask;
    logic [SUM_W-1:0]               y_sum;
    logic [SUM_W-1:0]               x_sum;
    logic [PY_W-1:0]                prod_y;
    logic [PX_W-1:0]                prod_x;
    logic [fbppw_pkg::ADDR_W-1:0]   addr_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_layout_reg   <= fbppw_pkg::RST_RED_LAYOUT;
            green_layout_reg <= fbppw_pkg::RST_GREEN_LAYOUT;
            blue_layout_reg  <= fbppw_pkg::RST_BLUE_LAYOUT;
            alpha_layout_reg <= fbppw_pkg::RST_ALPHA_LAYOUT;
            bpp_reg          <= fbppw_pkg::BPP_4;
            line_length_reg  <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fbppw_pkg::REG_RED_LAYOUT:
                    red_layout_reg   <= cfg_wr_data[fbppw_pkg::LAYOUT_W-1:0];
                fbppw_pkg::REG_GREEN_LAYOUT:
                    green_layout_reg <= cfg_wr_data[fbppw_pkg::LAYOUT_W-1:0];
                fbppw_pkg::REG_BLUE_LAYOUT:
                    blue_layout_reg  <= cfg_wr_data[fbppw_pkg::LAYOUT_W-1:0];
                fbppw_pkg::REG_ALPHA_LAYOUT:
                    alpha_layout_reg <= cfg_wr_data[fbppw_pkg::LAYOUT_W-1:0];
                fbppw_pkg::REG_BYTES_PER_PX:
                    bpp_reg          <= cfg_wr_data[fbppw_pkg::COUNT_W-1:0];
                fbppw_pkg::REG_LINE_LENGTH:
                    line_length_reg  <= cfg_wr_data[fbppw_pkg::STRIDE_W-1:0];
                fbppw_pkg::REG_ORIGIN_X:
                    origin_x_reg     <= cfg_wr_data[fbppw_pkg::COORD_W-1:0];
                fbppw_pkg::REG_ORIGIN_Y:
                    origin_y_reg     <= cfg_wr_data[fbppw_pkg::COORD_W-1:0];
                default:
                    bpp_reg          <= bpp_reg;
            endcase
        end
    end

    // Advance the pipeline whenever the result slot is free or being drained
    assign s1_advance   = !s2_valid_reg || pix_out.ready;
    assign pix_in.ready = !s1_valid_reg || s1_advance;
    assign in_take      = pix_in.valid && pix_in.ready;

    // Hold the input word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            s1_valid_reg <= pix_in.valid;
        end
    end

    // Capture the input word payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_argb_reg   <= pix_in.argb_pixel;
            s1_column_reg <= pix_in.column;
            s1_row_reg    <= pix_in.row;
        end
    end

    // Decode bytes per pixel: anything but 2 or 3 acts as 4
    always_comb
    begin
        if (bpp_reg == fbppw_pkg::BPP_2 || bpp_reg == fbppw_pkg::BPP_3)
        begin
            bpp_eff = bpp_reg;
        end
        else
        begin
            bpp_eff = fbppw_pkg::BPP_4;
        end
    end

    // Pack the four rescaled channels and mask unused bytes
    always_comb
    begin
        packed_word = rescale(s1_argb_reg[23:16], red_layout_reg)
                    | rescale(s1_argb_reg[15:8],  green_layout_reg)
                    | rescale(s1_argb_reg[7:0],   blue_layout_reg)
                    | rescale(s1_argb_reg[31:24], alpha_layout_reg);
        unique case (bpp_eff)
            fbppw_pkg::BPP_2: byte_mask = 32'h0000_FFFF;
            fbppw_pkg::BPP_3: byte_mask = 32'h00FF_FFFF;
            default:          byte_mask = 32'hFFFF_FFFF;
        endcase
    end

    // Form the byte address from row stride and pixel pitch
    always_comb
    begin
        y_sum     = {1'b0, origin_y_reg[USE_W-1:0]} + {1'b0, s1_row_reg[USE_W-1:0]};
        x_sum     = {1'b0, origin_x_reg[USE_W-1:0]} + {1'b0, s1_column_reg[USE_W-1:0]};
        prod_y    = PY_W'(y_sum) * PY_W'(line_length_reg);
        prod_x    = PX_W'(x_sum) * PX_W'(bpp_eff);
        addr_next = fbppw_pkg::ADDR_W'(prod_y) + fbppw_pkg::ADDR_W'(prod_x);
    end

    // Hold the result word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Load the result word payload
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            s2_addr_reg  <= addr_next;
            s2_bytes_reg <= packed_word & byte_mask;
            s2_count_reg <= bpp_eff;
        end
    end

    assign pix_out.valid        = s2_valid_reg;
    assign pix_out.byte_address = s2_addr_reg;
    assign pix_out.pixel_bytes  = s2_bytes_reg;
    assign pix_out.byte_count   = s2_count_reg;

    // A stalled input word stays in place
    `FBPPW_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_advance,
        s1_valid_reg && $stable(s1_argb_reg) && $stable(s1_row_reg))
    // Never accept over an input word that cannot move on
    `FBPPW_ASSERT_IMP(a_no_overrun, clk, rst_n, in_take, !s1_valid_reg || s1_advance)
    // Byte count is always a legal pitch
    `FBPPW_ASSERT_IMP(a_count_legal, clk, rst_n, s2_valid_reg,
        s2_count_reg == fbppw_pkg::BPP_2 || s2_count_reg == fbppw_pkg::BPP_3 ||
        s2_count_reg == fbppw_pkg::BPP_4)
    // Bytes above a two-byte pitch are cleared
    `FBPPW_ASSERT_IMP(a_mask_two, clk, rst_n,
        s2_valid_reg && s2_count_reg == fbppw_pkg::BPP_2, s2_bytes_reg[31:16] == 16'd0)

endmodule

// ===== tb/fbppw_write_checker.sv =====
// Checker for the pixel pack writer: predicts each framebuffer write and compares.
// Depends on fbppw_pkg, fbppw_in_if and fbppw_out_if; watches the channels and configuration port only.
`timescale 1ns / 1ps

module fbppw_write_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fbppw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbppw_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    fbppw_in_if                              pix_in,
    fbppw_out_if                             pix_out,
    output int                               fail_count,
    output int                               writes_outstanding,
    output int                               writes_checked
);

    import fbppw_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  byte_address;
        logic [PIXEL_W-1:0] pixel_bytes;
        logic [COUNT_W-1:0] byte_count;
    } fb_write_t;

    // Shadow copy of the block's registers
    logic [LAYOUT_W-1:0] red_lay;
    logic [LAYOUT_W-1:0] green_lay;
    logic [LAYOUT_W-1:0] blue_lay;
    logic [LAYOUT_W-1:0] alpha_lay;
    logic [COUNT_W-1:0]  bpp_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [COORD_W-1:0]  org_x;
    logic [COORD_W-1:0]  org_y;

    fb_write_t pending_writes[$];
    fb_write_t want;
    fb_write_t got;

    // Rescale an 8-bit channel to the layout's length, round to nearest, then place it
    function automatic logic [31:0] rescale_to_layout(input logic [7:0] v,
                                                      input logic [LAYOUT_W-1:0] lay);
        logic [5:0]  len;
        logic [4:0]  off;
        logic [63:0] full_scale;
        logic [63:0] scaled;
        len = lay[10:5];
        off = lay[4:0];
        if (len == 6'd0)
            return 32'd0;
        full_scale = (len >= 6'd32) ? 64'hFFFF_FFFF : ((64'd1 << len) - 64'd1);
        scaled = ({56'd0, v} * full_scale + 64'd127) / 64'd255;
        scaled = scaled << off;
        return scaled[31:0];
    endfunction

    // Work out the framebuffer write for one pixel under the current format
    function automatic fb_write_t pack_framebuffer_write(input logic [PIXEL_W-1:0] argb,
                                                         input logic [COORD_W-1:0] col,
                                                         input logic [COORD_W-1:0] row);
        fb_write_t          w;
        logic [COUNT_W-1:0] bpp;
        logic [31:0]        packed_px;
        logic [31:0]        keep;
        logic [63:0]        y_sum;
        logic [63:0]        x_sum;
        logic [63:0]        addr;
        bpp = (bpp_reg == BPP_2 || bpp_reg == BPP_3) ? bpp_reg : BPP_4;
        packed_px = rescale_to_layout(argb[23:16], red_lay)
                  | rescale_to_layout(argb[15:8], green_lay)
                  | rescale_to_layout(argb[7:0], blue_lay)
                  | rescale_to_layout(argb[31:24], alpha_lay);
        case (bpp)
            BPP_2:   keep = 32'h0000_FFFF;
            BPP_3:   keep = 32'h00FF_FFFF;
            default: keep = 32'hFFFF_FFFF;
        endcase
        y_sum = {52'd0, org_y} + {52'd0, row};
        x_sum = {52'd0, org_x} + {52'd0, col};
        addr = y_sum * {48'd0, stride_reg} + x_sum * {61'd0, bpp};
        w.byte_address = addr[31:0];
        w.pixel_bytes  = packed_px & keep;
        w.byte_count   = bpp;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_lay    = RST_RED_LAYOUT;
            green_lay  = RST_GREEN_LAYOUT;
            blue_lay   = RST_BLUE_LAYOUT;
            alpha_lay  = RST_ALPHA_LAYOUT;
            bpp_reg    = BPP_4;
            stride_reg = '0;
            org_x      = '0;
            org_y      = '0;
            pending_writes.delete();
            fail_count         = 0;
            writes_outstanding = 0;
            writes_checked     = 0;
        end
        else
        begin
            // Predict from the format in force before any write at this edge
            if (pix_in.valid && pix_in.ready)
                pending_writes.push_back(
                    pack_framebuffer_write(pix_in.argb_pixel, pix_in.column, pix_in.row));

            // Compare each delivered word with the oldest prediction
            if (pix_out.valid && pix_out.ready)
            begin
                got.byte_address = pix_out.byte_address;
                got.pixel_bytes  = pix_out.pixel_bytes;
                got.byte_count   = pix_out.byte_count;
                if (pending_writes.size() == 0)
                begin
                    $display("%0t: unexpected write word addr %h bytes %h count %0d",
                             $time, got.byte_address, got.pixel_bytes, got.byte_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    writes_checked++;
                    if (got.byte_address !== want.byte_address)
                    begin
                        $display("%0t: byte_address expected %h actual %h",
                                 $time, want.byte_address, got.byte_address);
                        fail_count++;
                    end
                    if (got.pixel_bytes !== want.pixel_bytes)
                    begin
                        $display("%0t: pixel_bytes expected %h actual %h",
                                 $time, want.pixel_bytes, got.pixel_bytes);
                        fail_count++;
                    end
                    if (got.byte_count !== want.byte_count)
                    begin
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, want.byte_count, got.byte_count);
                        fail_count++;
                    end
                end
            end

            // Track register writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RED_LAYOUT:   red_lay    = cfg_wr_data[LAYOUT_W-1:0];
                    REG_GREEN_LAYOUT: green_lay  = cfg_wr_data[LAYOUT_W-1:0];
                    REG_BLUE_LAYOUT:  blue_lay   = cfg_wr_data[LAYOUT_W-1:0];
                    REG_ALPHA_LAYOUT: alpha_lay  = cfg_wr_data[LAYOUT_W-1:0];
                    REG_BYTES_PER_PX: bpp_reg    = cfg_wr_data[COUNT_W-1:0];
                    REG_LINE_LENGTH:  stride_reg = cfg_wr_data[STRIDE_W-1:0];
                    REG_ORIGIN_X:     org_x      = cfg_wr_data[COORD_W-1:0];
                    REG_ORIGIN_Y:     org_y      = cfg_wr_data[COORD_W-1:0];
                    default:          ;
                endcase
            end

            writes_outstanding = pending_writes.size();
        end
    end

endmodule

// ===== tb/framebuffer_pixel_pack_writer_top_tb.sv =====
// Testbench top for the pixel pack writer: clock, reset, formats, pixel stimulus, verdict.
// Depends on fbppw_pkg, the channel interfaces, the block and fbppw_write_checker.
`timescale 1ns / 1ps

module framebuffer_pixel_pack_writer_top_tb;

    import fbppw_pkg::*;

    typedef struct packed {
        logic [LAYOUT_W-1:0] red;
        logic [LAYOUT_W-1:0] green;
        logic [LAYOUT_W-1:0] blue;
        logic [LAYOUT_W-1:0] alpha;
        logic [COUNT_W-1:0]  bpp;
        logic [STRIDE_W-1:0] stride;
        logic [COORD_W-1:0]  ox;
        logic [COORD_W-1:0]  oy;
    } fb_format_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    int fail_count;
    int writes_outstanding;
    int writes_checked;
    int pixels_sent;
    int formats_loaded;
    int tx_idle_pct;
    int rx_idle_pct;

    fbppw_in_if  in_ch ();
    fbppw_out_if out_ch ();

    framebuffer_pixel_pack_writer_top #(
        .COORD_BITS (12)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .pix_in      (in_ch),
        .pix_out     (out_ch)
    );

    fbppw_write_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .pix_in             (in_ch),
        .pix_out            (out_ch),
        .fail_count         (fail_count),
        .writes_outstanding (writes_outstanding),
        .writes_checked     (writes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the write side at the current rate
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Present one pixel word, idling first at the current rate; call at a falling edge
    task automatic send_pixel(input logic [PIXEL_W-1:0] argb, input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.argb_pixel <= argb;
        in_ch.column     <= col;
        in_ch.row        <= row;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge clk);
    endtask

    // Drain the pipeline, then write every register of the format
    task automatic load_format(input fb_format_t f);
        in_ch.valid <= 1'b0;
        while (writes_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(REG_RED_LAYOUT, CFG_DATA_W'(f.red));
        write_reg(REG_GREEN_LAYOUT, CFG_DATA_W'(f.green));
        write_reg(REG_BLUE_LAYOUT, CFG_DATA_W'(f.blue));
        write_reg(REG_ALPHA_LAYOUT, CFG_DATA_W'(f.alpha));
        write_reg(REG_BYTES_PER_PX, CFG_DATA_W'(f.bpp));
        write_reg(REG_LINE_LENGTH, f.stride);
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(f.ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(f.oy));
        cfg_wr_en <= 1'b0;
        formats_loaded++;
    endtask

    function automatic fb_format_t make_format(input int r, input int g, input int b, input int a,
                                               input int bpp, input int stride, input int ox,
                                               input int oy);
        fb_format_t f;
        f.red    = LAYOUT_W'(r);
        f.green  = LAYOUT_W'(g);
        f.blue   = LAYOUT_W'(b);
        f.alpha  = LAYOUT_W'(a);
        f.bpp    = COUNT_W'(bpp);
        f.stride = STRIDE_W'(stride);
        f.ox     = COORD_W'(ox);
        f.oy     = COORD_W'(oy);
        return f;
    endfunction

    // Mostly short channels, sometimes any length the field holds
    function automatic logic [LAYOUT_W-1:0] pick_layout();
        logic [5:0] len;
        logic [4:0] off;
        len = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 10));
        off = 5'($urandom_range(0, 31));
        return {len, off};
    endfunction

    function automatic fb_format_t random_format();
        fb_format_t f;
        case ($urandom_range(0, 4))
            0:       f = make_format(171, 197, 160, 0, int'(BPP_2), 0, 0, 0);
            1:       f = make_format(272, 264, 256, 0, int'(BPP_3), 0, 0, 0);
            2:       f = make_format(272, 264, 256, 280, int'(BPP_4), 0, 0, 0);
            default:
            begin
                f.red   = pick_layout();
                f.green = pick_layout();
                f.blue  = pick_layout();
                f.alpha = pick_layout();
                f.bpp   = COUNT_W'($urandom_range(0, 7));
            end
        endcase
        if ($urandom_range(0, 3) != 0)
            f.bpp = COUNT_W'($urandom_range(2, 4));
        f.stride = STRIDE_W'($urandom_range(0, 65535));
        f.ox     = COORD_W'($urandom_range(0, 4095));
        f.oy     = COORD_W'($urandom_range(0, 4095));
        return f;
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic run_random_block(input int count);
        logic [PIXEL_W-1:0] argb;
        load_format(random_format());
        repeat (count)
        begin
            if ($urandom_range(0, 1) == 0)
                argb = $urandom;
            else
                argb = {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
            send_pixel(argb, pick_coord(), pick_coord());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        in_ch.valid    = 1'b0;
        in_ch.argb_pixel = '0;
        in_ch.column   = '0;
        in_ch.row      = '0;
        out_ch.ready   = 1'b0;
        pixels_sent    = 0;
        formats_loaded = 0;
        tx_idle_pct    = 6;
        rx_idle_pct    = 74;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset format: 8-bit RGB, 4 bytes, zero stride and origin
        send_pixel(32'hFFFF_FFFF, 0, 0);
        send_pixel(32'h0000_0000, 12'hFFF, 12'hFFF);
        send_pixel(32'h1234_5678, 1, 2);

        // Full ARGB at the largest stride and origin: highest address
        load_format(make_format(272, 264, 256, 280, int'(BPP_4), 65535, 4095, 4095));
        send_pixel(32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        send_pixel(32'h807F_01FE, 0, 0);

        // 16-bit 565: rounding at the channel midpoints, top bytes masked
        load_format(make_format(171, 197, 160, 0, int'(BPP_2), 1280, 10, 20));
        send_pixel(32'hFFFF_FFFF, 3, 4);
        send_pixel(32'h0000_0000, 12'hFFF, 0);
        send_pixel(32'h0080_8080, 0, 12'hFFF);
        send_pixel(32'h007F_7F7F, 100, 200);
        send_pixel(32'hA5F8_0401, 7, 9);

        // 24-bit packing
        load_format(make_format(272, 264, 256, 0, int'(BPP_3), 4000, 1, 1));
        send_pixel(32'h00FF_FFFF, 5, 6);
        send_pixel(32'hFF12_3456, 4095, 1);

        // 32-bit lengths at offset 31: bits pushed past the top; invalid byte count
        load_format(make_format(1055, 1055, 1055, 1055, 0, 0, 0, 0));
        send_pixel(32'hFFFF_FFFF, 0, 0);
        send_pixel(32'h0101_0101, 1, 1);

        // Length beyond 32, zero length with an offset, byte count 7
        load_format(make_format(2016, 31, 1024, 31, 7, 3, 4095, 0));
        send_pixel(32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        send_pixel(32'h5A5A_5A5A, 2, 3);

        // Overlapping channels ORed together
        load_format(make_format(260, 256, 258, 156, int'(BPP_3), 65535, 0, 4095));
        send_pixel(32'hF0C3_3C0F, 0, 1);
        send_pixel(32'h8001_FF80, 4095, 4095);

        // Random formats and pixels: sender mostly busy and receiver mostly stalled, then the reverse, then no idling
        repeat (2) run_random_block(100);
        tx_idle_pct = 74;
        rx_idle_pct = 6;
        repeat (2) run_random_block(100);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (3) run_random_block(100);

        // Drain and let the pipeline settle
        in_ch.valid <= 1'b0;
        while (writes_outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d pixels under %0d register formats plus the reset format;",
                 pixels_sent, formats_loaded);
        $display("checked %0d framebuffer writes with random stalls on both sides.",
                 writes_checked);
        if (fail_count == 0 && writes_outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fbppw_pkg.sv
rtl/fbppw_in_if.sv
rtl/fbppw_out_if.sv
rtl/framebuffer_pixel_pack_writer_top.sv
tb/fbppw_write_checker.sv
tb/framebuffer_pixel_pack_writer_top_tb.sv
